// ===== sv/frc_pkg.sv =====
// Shared constants, lookup tables and control structs of the formant resonator cascade.
// No dependencies; the files that use it refer to it by scoped names.
package frc_pkg;

  localparam int SECTIONS    = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int TABLE_BITS  = 10;

  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int TBL_N  = 1 << TABLE_BITS;
  localparam int TBL_Q  = 1 << (TABLE_BITS - 2);
  localparam int FR_W   = 32 - TABLE_BITS;
  localparam int HIST_W = 40;
  localparam int COEF_W = 24;

  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_ONE    = 2'd1;
  localparam logic [1:0] MODE_TWO    = 2'd2;

  localparam logic signed [31:0] CLOSE_TO_ONE = 32'sd1073740750;
  localparam logic [20:0]        SCALE_Q20    = 21'd1038090;
  localparam logic [19:0]        PI_LOG2E_Q16 = 20'd297034;

  typedef logic signed [31:0] cos_rom_t [TBL_Q + 1];
  typedef logic signed [31:0] exp_rom_t [TBL_N + 1];

  typedef struct packed {
    logic             valid;
    logic [2:0]       sec;
    logic [15:0]      fhz;
    logic [15:0]      bhz;
    logic             defined;
  } upd_req_t;

  typedef struct packed {
    logic                     we;
    logic [SEC_W-1:0]         addr;
    logic [1:0]               mode;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
  } coef_wr_t;

  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sos;
  } filt_req_t;

  typedef struct packed {
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip;
  } filt_rsp_t;

  // Quarter-wave cosine in Q30 from a truncated Taylor series
  function automatic cos_rom_t build_cos();
    cos_rom_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      sum;
    for (int i = 0; i <= TBL_Q; i++) begin
      x   = (64'd1686629713 * 64'(i)) / 64'(TBL_Q);
      x2  = (x * x) >> 30;
      t   = 64'd1 << 30;
      sum = longint'(1) << 30;
      for (int k = 1; k <= 12; k++) begin
        t = ((t * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        if ((k % 2) == 1) sum = sum - longint'(t);
        else sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      tab[i] = 32'(sum);
    end
    return tab;
  endfunction

  // 2^-(i/TBL_N) in Q30
  function automatic exp_rom_t build_exp();
    exp_rom_t    tab;
    logic [63:0] y;
    logic [63:0] t;
    longint      sum;
    for (int i = 0; i <= TBL_N; i++) begin
      y   = (64'd744261118 * 64'(i)) / 64'(TBL_N);
      t   = 64'd1 << 30;
      sum = longint'(1) << 30;
      for (int k = 1; k <= 14; k++) begin
        t = ((t * y) >> 30) / 64'(k);
        if ((k % 2) == 1) sum = sum - longint'(t);
        else sum = sum + longint'(t);
      end
      tab[i] = 32'(sum);
    end
    return tab;
  endfunction

  localparam cos_rom_t COS_TAB = build_cos();
  localparam exp_rom_t EXP_TAB = build_exp();

  // Full-wave cosine from the quarter table by symmetry
  function automatic logic signed [31:0] cos_at(input logic [TABLE_BITS-1:0] p);
    logic [1:0]            q;
    logic [TABLE_BITS-2:0] jf;
    logic [TABLE_BITS-2:0] jr;
    q  = p[TABLE_BITS-1 -: 2];
    jf = {1'b0, p[TABLE_BITS-3:0]};
    jr = (TABLE_BITS - 1)'(TBL_Q) - jf;
    case (q)
      2'd0:    return COS_TAB[jf];
      2'd1:    return -COS_TAB[jr];
      2'd2:    return -COS_TAB[jf];
      default: return COS_TAB[jr];
    endcase
  endfunction

endpackage

// ===== sv/frc_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on frc_pkg for the sample width.
interface frc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   op;
  logic signed [frc_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                   start_of_sound;
  logic [2:0]                             section_index;
  logic [15:0]                            formant_hz;
  logic [15:0]                            bandwidth_hz;
  logic                                   values_defined;

  modport source (output valid, op, sample_in, start_of_sound, section_index, formant_hz,
                  bandwidth_hz, values_defined, input ready);
  modport sink (input valid, op, sample_in, start_of_sound, section_index, formant_hz,
                bandwidth_hz, values_defined, output ready);
endinterface

interface frc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [frc_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink (input valid, sample_out, clipped, output ready);
endinterface

// ===== sv/frc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/frc_coef.sv =====
// Coefficient sequencer: turns formant and bandwidth into section mode and coefficients.
// Depends on frc_pkg (tables, structs); one shared multiplier, one registered exp ROM.
module frc_coef (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frc_pkg::upd_req_t  req_i,
  input  logic [31:0]        phase_per_hz_i,
  output frc_pkg::coef_wr_t  wr_o,
  output logic               done_o
);
  localparam logic [3:0] K_IDLE = 4'd0;
  localparam logic [3:0] K_PH   = 4'd1;
  localparam logic [3:0] K_BP   = 4'd2;
  localparam logic [3:0] K_W    = 4'd3;
  localparam logic [3:0] K_C    = 4'd4;
  localparam logic [3:0] K_E0   = 4'd5;
  localparam logic [3:0] K_E1   = 4'd6;
  localparam logic [3:0] K_C1   = 4'd7;
  localparam logic [3:0] K_C2   = 4'd8;

  localparam int TB = frc_pkg::TABLE_BITS;
  localparam int FW = frc_pkg::FR_W;

  logic [3:0]         state_q, state_d;
  logic [2:0]         sec_q;
  logic [15:0]        fhz_q, bhz_q;
  logic               def_q;
  logic [31:0]        ph_q;
  logic [47:0]        bp_q;
  logic [37:0]        w_q;
  logic               big_q;
  logic signed [31:0] ca_q, cb_q, c_q, ea_q, rom_q;
  logic [30:0]        r_q;
  logic [1:0]         mode_q;
  logic signed [23:0] c1_q;

  logic [TB:0]        rom_addr;
  logic signed [35:0] ma;
  logic signed [32:0] mb;
  logic signed [68:0] prod;
  logic signed [68:0] rnd22, rnd37, rnd38;
  logic signed [31:0] e_sum;
  logic [31:0]        e_u;
  logic               r_zero;
  logic               close;
  logic signed [23:0] c1_two;
  logic signed [23:0] c2_val;

  assign rom_addr = (state_q == K_E0) ? ((TB + 1)'({1'b0, w_q[31:FW]}) + 1'b1)
                                      : {1'b0, w_q[31:FW]};

  always_ff @(posedge clk_i) begin
    rom_q <= frc_pkg::EXP_TAB[rom_addr];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      K_PH: begin
        ma = 36'(fhz_q);
        mb = 33'(phase_per_hz_i);
      end
      K_BP: begin
        ma = 36'(bhz_q);
        mb = 33'(phase_per_hz_i);
      end
      K_W: begin
        ma = 36'(bp_q[34:0]);
        mb = 33'(frc_pkg::PI_LOG2E_Q16);
      end
      K_C: begin
        ma = 36'(cb_q) - 36'(ca_q);
        mb = 33'(ph_q[FW-1:0]);
      end
      K_E1: begin
        ma = 36'(rom_q) - 36'(ea_q);
        mb = 33'(w_q[FW-1:0]);
      end
      K_C1: begin
        ma = 36'(r_q);
        mb = 33'(c_q);
      end
      K_C2: begin
        ma = 36'(r_q);
        mb = 33'(r_q);
      end
      default: ;
    endcase
  end

  assign prod  = ma * mb;
  assign rnd22 = (prod + (69'sd1 <<< 21)) >>> 22;
  assign rnd37 = (prod + (69'sd1 <<< 36)) >>> 37;
  assign rnd38 = (prod + (69'sd1 <<< 37)) >>> 38;
  assign e_sum = ea_q + 32'(rnd22);
  assign e_u   = e_sum;
  // Zero decay once the bandwidth phase or the exponent gets too large
  assign r_zero = big_q || (w_q[37:32] >= 6'd31);
  assign close  = (c_q > frc_pkg::CLOSE_TO_ONE) || (c_q < -frc_pkg::CLOSE_TO_ONE);

  always_comb begin
    if (rnd37 > 69'sd8388607) c1_two = 24'sh7FFFFF;
    else if (rnd37 < -69'sd8388608) c1_two = -24'sh800000;
    else c1_two = 24'(rnd37);
  end

  assign c2_val = (mode_q == frc_pkg::MODE_TWO) ? 24'(rnd38) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      K_IDLE: if (req_i.valid) state_d = req_i.defined ? K_PH : K_C1;
      K_PH:   state_d = K_BP;
      K_BP:   state_d = K_W;
      K_W:    state_d = K_C;
      K_C:    state_d = K_E0;
      K_E0:   state_d = K_E1;
      K_E1:   state_d = K_C1;
      K_C1:   state_d = K_C2;
      K_C2:   state_d = K_IDLE;
      default: state_d = K_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= K_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      K_IDLE: begin
        sec_q <= req_i.sec;
        fhz_q <= req_i.fhz;
        bhz_q <= req_i.bhz;
        def_q <= req_i.defined;
      end
      K_PH: ph_q <= prod[31:0];
      K_BP: bp_q <= prod[47:0];
      K_W: begin
        w_q   <= prod[53:16];
        big_q <= bp_q >= (48'd6 << 32);
        ca_q  <= frc_pkg::cos_at(ph_q[31:FW]);
        cb_q  <= frc_pkg::cos_at(ph_q[31:FW] + 1'b1);
      end
      K_C:  c_q <= ca_q + 32'(rnd22);
      K_E0: ea_q <= rom_q;
      K_E1: r_q <= r_zero ? '0 : 31'(e_u >> w_q[36:32]);
      K_C1: begin
        if (!def_q) begin
          mode_q <= frc_pkg::MODE_BYPASS;
          c1_q   <= '0;
        end else if (close) begin
          mode_q <= frc_pkg::MODE_ONE;
          c1_q   <= 24'(({1'b0, r_q} + 32'd128) >> 8);
        end else begin
          mode_q <= frc_pkg::MODE_TWO;
          c1_q   <= c1_two;
        end
      end
      default: ;
    endcase
  end

  assign done_o  = (state_q == K_C2);
  assign wr_o.we = done_o && (32'(sec_q) < frc_pkg::SECTIONS);
  assign wr_o.addr = frc_pkg::SEC_W'(sec_q);
  assign wr_o.mode = mode_q;
  assign wr_o.c1   = c1_q;
  assign wr_o.c2   = c2_val;
endmodule

// ===== sv/frc_filt.sv =====
// Filter sequencer: runs a sample through the sections, coefficients and histories in RAM.
// Depends on frc_pkg and frc_ram.
module frc_filt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frc_pkg::filt_req_t req_i,
  input  frc_pkg::coef_wr_t  wr_i,
  input  logic               scale_on_i,
  input  logic               out_free_i,
  output frc_pkg::filt_rsp_t rsp_o
);
  localparam int SW = frc_pkg::SEC_W;
  localparam int HW = frc_pkg::HIST_W;
  localparam int CW = frc_pkg::COEF_W;
  localparam int NS = frc_pkg::SECTIONS;
  localparam int XW = frc_pkg::SAMPLE_BITS;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_RD   = 3'd1;
  localparam logic [2:0] F_M1   = 3'd2;
  localparam logic [2:0] F_M2   = 3'd3;
  localparam logic [2:0] F_WB   = 3'd4;
  localparam logic [2:0] F_SC   = 3'd5;
  localparam logic [2:0] F_OUT  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [SW-1:0]        sec_q;
  logic [NS-1:0]        cv_q, hv_q;
  logic signed [HW-1:0] x_q, y1_q, y2_q;
  logic signed [CW-1:0] c2_q;
  logic [1:0]           mode_q;
  logic signed [64:0]   p1_q, p2_q;
  logic                 clip_q;

  logic [SW-1:0]        rd_addr;
  logic [2+2*CW-1:0]    coef_rd;
  logic [2*HW-1:0]      hist_rd;
  logic                 cvld, hvld;
  logic signed [HW-1:0] h_y1, h_y2;
  logic signed [CW-1:0] k_c1, k_c2;
  logic signed [HW-1:0] ma;
  logic signed [24:0]   mb;
  logic signed [64:0]   prod;
  logic signed [65:0]   diff;
  logic signed [43:0]   acc;
  logic signed [44:0]   sum;
  logic signed [HW-1:0] y;
  logic                 y_sat;
  logic                 last;
  logic signed [64:0]   scaled;
  logic signed [XW-1:0] o_val;
  logic                 o_sat;

  assign rd_addr = (state_q == F_WB) ? SW'(sec_q + 1'b1) : sec_q;

  frc_ram #(.WIDTH(2 + 2 * CW), .DEPTH(NS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.we),
    .waddr_i (wr_i.addr),
    .wdata_i ({wr_i.mode, wr_i.c1, wr_i.c2}),
    .raddr_i (rd_addr),
    .rdata_o (coef_rd)
  );

  frc_ram #(.WIDTH(2 * HW), .DEPTH(NS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == F_WB),
    .waddr_i (sec_q),
    .wdata_i ({y, y1_q}),
    .raddr_i (rd_addr),
    .rdata_o (hist_rd)
  );

  // Entries never written read as zero / bypass
  assign cvld = cv_q[sec_q];
  assign hvld = hv_q[sec_q];
  assign h_y1 = hvld ? hist_rd[2*HW-1:HW] : '0;
  assign h_y2 = hvld ? hist_rd[HW-1:0] : '0;
  assign k_c1 = cvld ? coef_rd[2*CW-1:CW] : '0;
  assign k_c2 = cvld ? coef_rd[CW-1:0] : '0;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      F_M1: begin
        ma = h_y1;
        mb = 25'(k_c1);
      end
      F_M2: begin
        ma = y2_q;
        mb = 25'(c2_q);
      end
      F_SC: begin
        ma = x_q;
        mb = 25'(frc_pkg::SCALE_Q20);
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign diff = 66'(p1_q) - 66'(p2_q);
  assign acc  = 44'((diff + (66'sd1 <<< 21)) >>> 22);
  assign sum  = ((mode_q == frc_pkg::MODE_ONE) || (mode_q == frc_pkg::MODE_TWO))
                ? (45'(x_q) + 45'(acc)) : 45'(x_q);

  always_comb begin
    y_sat = 1'b1;
    if (sum > 45'sh7F_FFFF_FFFF) y = {1'b0, {(HW-1){1'b1}}};
    else if (sum < -45'sh80_0000_0000) y = {1'b1, {(HW-1){1'b0}}};
    else begin
      y     = HW'(sum);
      y_sat = 1'b0;
    end
  end

  assign last   = (sec_q == SW'(NS - 1));
  assign scaled = scale_on_i ? ((p1_q + (65'sd1 <<< 19)) >>> 20) : 65'(x_q);

  always_comb begin
    o_sat = 1'b1;
    if (scaled > 65'(2 ** (XW - 1) - 1)) o_val = {1'b0, {(XW-1){1'b1}}};
    else if (scaled < -65'(2 ** (XW - 1))) o_val = {1'b1, {(XW-1){1'b0}}};
    else begin
      o_val = XW'(scaled);
      o_sat = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (req_i.valid) state_d = F_RD;
      F_RD:   state_d = F_M1;
      F_M1:   state_d = F_M2;
      F_M2:   state_d = F_WB;
      F_WB:   state_d = last ? F_SC : F_M1;
      F_SC:   state_d = F_OUT;
      F_OUT:  if (out_free_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cv_q    <= '0;
      hv_q    <= '0;
    end else begin
      state_q <= state_d;
      if (wr_i.we) cv_q[wr_i.addr] <= 1'b1;
      if (state_q == F_IDLE && req_i.valid && req_i.sos) hv_q <= '0;
      if (state_q == F_WB) hv_q[sec_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        sec_q  <= '0;
        x_q    <= HW'(req_i.sample);
        clip_q <= 1'b0;
      end
      F_M1: begin
        p1_q   <= prod;
        y1_q   <= h_y1;
        y2_q   <= h_y2;
        c2_q   <= k_c2;
        mode_q <= cvld ? coef_rd[2*CW+1:2*CW] : frc_pkg::MODE_BYPASS;
      end
      F_M2: p2_q <= prod;
      F_WB: begin
        x_q    <= y;
        clip_q <= clip_q | y_sat;
        sec_q  <= SW'(sec_q + 1'b1);
      end
      F_SC: p1_q <= prod;
      default: ;
    endcase
  end

  assign rsp_o.done   = (state_q == F_OUT) && out_free_i;
  assign rsp_o.sample = o_val;
  assign rsp_o.clip   = clip_q | o_sat;
endmodule

// ===== sv/formant_resonator_cascade.sv =====
// Top level of the formant resonator cascade: register port, dispatch, output register.
// Depends on frc_pkg, frc_if, frc_coef and frc_filt.
//
// Input words arrive on in_if_i (valid/ready). A word with op 0 filters one sample
// through all sections and yields one result word on out_if_o; a word with op 1
// reloads one section's coefficients and yields nothing.
// One word is worked on at a time. A sample goes through a read step, then each
// section in turn spends a y1 product step, a y2 product step and a history
// write-back step, all through a single multiplier and the coefficient and history
// RAMs; a scaling step and an output step follow, and the output step loads the
// output register. An update runs through the coefficient sequencer's steps; one
// that marks the section undefined skips to the last two of them.
// A finished result waits in the output register; the next word is taken meanwhile,
// and a following sample waits in its final step while the receiver stalls.
// Reset sets all sections to bypass, clears histories and restores the register
// defaults; the RAMs need no clearing pass. Registers: phase_per_hz at 0x0,
// output_scale_on at 0x4.
module formant_resonator_cascade (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  frc_in_if.sink      in_if_i,
  frc_out_if.source   out_if_o
);
  localparam logic REG_PHASE = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  logic [31:0] pph_q;
  logic        scl_q;
  logic        busy_q;
  logic        ov_q;
  logic signed [frc_pkg::SAMPLE_BITS-1:0] osample_q;
  logic        oclip_q;

  logic               accept;
  logic               out_free;
  logic               coef_done;
  frc_pkg::upd_req_t  upd_req;
  frc_pkg::coef_wr_t  coef_wr;
  frc_pkg::filt_req_t filt_req;
  frc_pkg::filt_rsp_t filt_rsp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCALE) ? {31'b0, scl_q} : pph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pph_q <= 32'd97391;
      scl_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PHASE) pph_q <= pwdata;
      else scl_q <= pwdata[0];
    end
  end

  assign in_if_i.ready = !busy_q;
  assign accept        = in_if_i.valid && !busy_q;
  assign out_free      = !ov_q || out_if_o.ready;

  assign upd_req.valid   = accept && in_if_i.op;
  assign upd_req.sec     = in_if_i.section_index;
  assign upd_req.fhz     = in_if_i.formant_hz;
  assign upd_req.bhz     = in_if_i.bandwidth_hz;
  assign upd_req.defined = in_if_i.values_defined;

  assign filt_req.valid  = accept && !in_if_i.op;
  assign filt_req.sample = in_if_i.sample_in;
  assign filt_req.sos    = in_if_i.start_of_sound;

  frc_coef u_coef (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (upd_req),
    .phase_per_hz_i (pph_q),
    .wr_o           (coef_wr),
    .done_o         (coef_done)
  );

  frc_filt u_filt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (filt_req),
    .wr_i       (coef_wr),
    .scale_on_i (scl_q),
    .out_free_i (out_free),
    .rsp_o      (filt_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (accept) busy_q <= 1'b1;
      else if (coef_done || filt_rsp.done) busy_q <= 1'b0;
      if (filt_rsp.done) ov_q <= 1'b1;
      else if (out_if_o.ready) ov_q <= 1'b0;
    end
  end

  // Hold the word until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (filt_rsp.done) begin
      osample_q <= filt_rsp.sample;
      oclip_q   <= filt_rsp.clip;
    end
  end

  assign out_if_o.valid      = ov_q;
  assign out_if_o.sample_out = osample_q;
  assign out_if_o.clipped    = oclip_q;
endmodule
